// File: rtl/lfuc_pkg.sv
// Shared types, constants and state codes for the LFU cache with LRU tie-break.
package lfuc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int CAP_W       = 5;
	localparam int WORD_W      = 32;
	localparam int COUNT_W     = 32;
	localparam int STAMP_W     = 48;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [WORD_W-1:0] key;
		logic signed [WORD_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic                     hit;
		logic signed [WORD_W-1:0] read_value;
		logic                     evicted;
		logic signed [WORD_W-1:0] evicted_key;
	} result_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] key;
		logic signed [WORD_W-1:0] value;
		logic [COUNT_W-1:0]       count;
		logic [STAMP_W-1:0]       stamp;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FINISH
	} state_t;

	// Control from the sequencer to the selection unit.
	typedef struct packed {
		logic clear;
		logic rd_valid;
		logic entry_valid;
	} pick_ctl_t;

endpackage

// File: rtl/lfu_cache_lru_tiebreak.sv
// Top level of the LFU cache with LRU tie-break: sequencer, valid bits and result register.
//
//  channel  | signals                      | handshake
//  ---------+------------------------------+-------------------------------------
//  command  | start, busy, item            | word taken when start & !busy
//  result   | done, result                 | word shown for one cycle under done
//  config   | cfg_valid, cfg_ready, cfg_data| capacity written when valid & ready
//
// An operation scans n entries, where n is min(capacity, ENTRIES, 31): one entry
// memory read per cycle in ST_SCAN, ST_LAST for the read latency, then the write
// back in ST_FINISH, after which done is raised. Capacity zero skips the scan.
// Reset clears the valid bits, the stamp counter and the capacity to 16 at once.
// Results cannot be stalled; a new command may be taken in the cycle done is high.
module lfu_cache_lru_tiebreak #(
	parameter int ENTRIES = lfuc_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  lfuc_pkg::item_t                     item,
	output logic                                done,
	output lfuc_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lfuc_pkg::CAP_W-1:0]          cfg_data
);

	// Capacity is five bits, so no slot above 30 is ever in use.
	localparam int USED = (ENTRIES < 31) ? ENTRIES : 31;
	localparam int IW   = (USED > 1) ? $clog2(USED) : 1;
	localparam logic [lfuc_pkg::CAP_W-1:0] USED_C = lfuc_pkg::CAP_W'(USED);

	lfuc_pkg::state_t state_q, state_d;

	logic [lfuc_pkg::CAP_W-1:0]   capacity_q;
	logic [lfuc_pkg::CAP_W-1:0]   n_q;
	logic [lfuc_pkg::CAP_W-1:0]   n_d;
	lfuc_pkg::item_t              item_q;
	logic [USED-1:0]              valid_q;
	logic [lfuc_pkg::STAMP_W-1:0] stamp_q;
	logic [IW-1:0]                addr_q;
	logic                         rd_s1;
	logic [IW-1:0]                idx_s1;
	logic                         done_q;
	lfuc_pkg::result_t            result_q;

	logic                         accept;
	logic                         last_addr;
	logic                         rd_en;
	lfuc_pkg::entry_t             rd_data;
	logic                         wr_en;
	logic [IW-1:0]                wr_addr;
	lfuc_pkg::entry_t             wr_data;
	logic                         set_valid;
	lfuc_pkg::result_t            result_d;
	lfuc_pkg::pick_ctl_t          pick_ctl;

	logic                               found;
	logic [IW-1:0]                      found_idx;
	logic signed [lfuc_pkg::WORD_W-1:0] found_value;
	logic [lfuc_pkg::COUNT_W-1:0]       found_count;
	logic                               free;
	logic [IW-1:0]                      free_idx;
	logic [IW-1:0]                      victim_idx;
	logic signed [lfuc_pkg::WORD_W-1:0] victim_key;
	logic [lfuc_pkg::COUNT_W-1:0]       bumped_count;

	assign accept    = start && (state_q == lfuc_pkg::ST_IDLE);
	assign n_d       = (capacity_q > USED_C) ? USED_C : capacity_q;
	assign last_addr = (lfuc_pkg::CAP_W'(addr_q) + lfuc_pkg::CAP_W'(1)) == n_q;
	assign bumped_count = (found_count == '1) ? found_count : found_count + 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lfuc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (n_d == '0) ? lfuc_pkg::ST_FINISH : lfuc_pkg::ST_SCAN;
				end
			end
			lfuc_pkg::ST_SCAN: begin
				if (last_addr) begin
					state_d = lfuc_pkg::ST_LAST;
				end
			end
			lfuc_pkg::ST_LAST:   state_d = lfuc_pkg::ST_FINISH;
			lfuc_pkg::ST_FINISH: state_d = lfuc_pkg::ST_IDLE;
			default:             state_d = lfuc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = found_idx;
		wr_data   = '{key: item_q.key, value: found_value, count: bumped_count,
			stamp: stamp_q};
		set_valid = 1'b0;
		result_d  = '0;
		case (state_q)
			lfuc_pkg::ST_SCAN: begin
				rd_en = 1'b1;
			end
			lfuc_pkg::ST_FINISH: begin
				if (item_q.cmd == lfuc_pkg::CMD_GET) begin
					result_d.hit = found;
					if (found) begin
						result_d.read_value = found_value;
						wr_en = 1'b1;
					end
				end else if (n_q != '0) begin
					wr_en = 1'b1;
					if (found) begin
						result_d.hit  = 1'b1;
						wr_data.value = item_q.value;
					end else begin
						set_valid     = 1'b1;
						wr_data.value = item_q.value;
						wr_data.count = lfuc_pkg::COUNT_W'(1);
						if (free) begin
							wr_addr = free_idx;
						end else begin
							wr_addr              = victim_idx;
							result_d.evicted     = 1'b1;
							result_d.evicted_key = victim_key;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lfuc_pkg::ST_IDLE;
			capacity_q <= lfuc_pkg::CAP_RESET;
			valid_q    <= '0;
			stamp_q    <= '0;
			rd_s1      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= rd_en;
			done_q  <= (state_q == lfuc_pkg::ST_FINISH);
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (wr_en) begin
				stamp_q <= stamp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			n_q    <= n_d;
			addr_q <= '0;
		end else if (rd_en) begin
			addr_q <= addr_q + IW'(1);
		end
		idx_s1 <= addr_q;
		if (state_q == lfuc_pkg::ST_FINISH) begin
			result_q <= result_d;
		end
	end

	assign pick_ctl.clear       = accept;
	assign pick_ctl.rd_valid    = rd_s1;
	assign pick_ctl.entry_valid = valid_q[idx_s1];

	lfuc_mem #(
		.DEPTH (USED),
		.IW    (IW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lfuc_pick #(
		.IW (IW)
	) u_pick (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (pick_ctl),
		.idx         (idx_s1),
		.data        (rd_data),
		.key         (item_q.key),
		.found       (found),
		.found_idx   (found_idx),
		.found_value (found_value),
		.found_count (found_count),
		.free        (free),
		.free_idx    (free_idx),
		.victim_idx  (victim_idx),
		.victim_key  (victim_key)
	);

	assign busy      = (state_q != lfuc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

endmodule

// File: rtl/lfuc_mem.sv
// Entry memory: one write port and one synchronous read port.
module lfuc_mem #(
	parameter int DEPTH = lfuc_pkg::ENTRIES_DEF,
	parameter int IW    = 4
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [IW-1:0]        rd_addr,
	output lfuc_pkg::entry_t     rd_data,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_addr,
	input  lfuc_pkg::entry_t     wr_data
);

	lfuc_pkg::entry_t mem [DEPTH];
	lfuc_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/lfuc_pick.sv
// Scan selection unit: tracks the key match, the first free slot and the eviction victim.
module lfuc_pick #(
	parameter int IW = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfuc_pkg::pick_ctl_t                ctl,
	input  logic [IW-1:0]                      idx,
	input  lfuc_pkg::entry_t                   data,
	input  logic signed [lfuc_pkg::WORD_W-1:0] key,
	output logic                               found,
	output logic [IW-1:0]                      found_idx,
	output logic signed [lfuc_pkg::WORD_W-1:0] found_value,
	output logic [lfuc_pkg::COUNT_W-1:0]       found_count,
	output logic                               free,
	output logic [IW-1:0]                      free_idx,
	output logic [IW-1:0]                      victim_idx,
	output logic signed [lfuc_pkg::WORD_W-1:0] victim_key
);

	logic                               found_q;
	logic [IW-1:0]                      found_idx_q;
	logic signed [lfuc_pkg::WORD_W-1:0] found_value_q;
	logic [lfuc_pkg::COUNT_W-1:0]       found_count_q;
	logic                               free_q;
	logic [IW-1:0]                      free_idx_q;
	logic                               victim_q;
	logic [IW-1:0]                      victim_idx_q;
	logic signed [lfuc_pkg::WORD_W-1:0] victim_key_q;
	logic [lfuc_pkg::COUNT_W-1:0]       victim_count_q;
	logic [lfuc_pkg::STAMP_W-1:0]       victim_stamp_q;
	logic                               take_victim;

	// Lower count wins; on equal count the older stamp wins; full ties keep the earlier slot.
	assign take_victim = !victim_q || (data.count < victim_count_q) ||
		((data.count == victim_count_q) && (data.stamp < victim_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			victim_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			victim_q <= 1'b0;
		end else if (ctl.rd_valid) begin
			if (ctl.entry_valid) begin
				if (!found_q && data.key == key) begin
					found_q <= 1'b1;
				end
				if (take_victim) begin
					victim_q <= 1'b1;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_valid && ctl.entry_valid) begin
			if (!found_q && data.key == key) begin
				found_idx_q   <= idx;
				found_value_q <= data.value;
				found_count_q <= data.count;
			end
			if (take_victim) begin
				victim_idx_q   <= idx;
				victim_key_q   <= data.key;
				victim_count_q <= data.count;
				victim_stamp_q <= data.stamp;
			end
		end
		if (ctl.rd_valid && !ctl.entry_valid && !free_q) begin
			free_idx_q <= idx;
		end
	end

	assign found       = found_q;
	assign found_idx   = found_idx_q;
	assign found_value = found_value_q;
	assign found_count = found_count_q;
	assign free        = free_q;
	assign free_idx    = free_idx_q;
	assign victim_idx  = victim_idx_q;
	assign victim_key  = victim_key_q;

endmodule

// File: rtl/lfuc_checker.sv
// Port-level checker for the LFU cache, bound to the top level.
module lfuc_port_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input lfuc_pkg::result_t          result
);

	// A result word appears only once the command has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command ended without a result word");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.evicted) |-> !result.hit)
		else $error("eviction reported on a hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.read_value == '0))
		else $error("read value nonzero on a miss");

endmodule

bind lfu_cache_lru_tiebreak lfuc_port_checks u_lfuc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
